@@ hw/rtl/htp_pkg.sv @@
// Package for the hash table triangular probe unit: sizes, codes, types and helpers.
// No dependencies; imported by htp_mod, the top unit and the testbench.
`default_nettype none
package htp_pkg;

   localparam int CAPACITY  = 64;
   localparam int KEY_BYTES = 8;

   localparam int KEY_W   = 64;
   localparam int PHONE_W = 64;
   localparam int SLOT_W  = 6;
   localparam int SIZE_W  = 7;
   localparam int STAT_W  = 2;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int SUM_W  = $clog2(KEY_BYTES * 255 + 1);
   localparam int STEP_W = $clog2(SUM_W + 1);

   localparam int ENTRY_W = KEY_W + PHONE_W;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic CSR_SEL_TABLE_SIZE = 1'b0;

   localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(64);

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] ST_FOUND     = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] rem;
   } htp_mod_rsp_type;

   function automatic logic [KEY_W-1:0] key_mask();
      logic [KEY_W-1:0] m;
      m = '0;
      for (int i = 0; i < KEY_BYTES && i < KEY_W / 8; i++) begin
         m[8*i +: 8] = 8'hFF;
      end
      return m;
   endfunction

   function automatic logic [SUM_W-1:0] byte_sum(input logic [KEY_W-1:0] key);
      logic [SUM_W-1:0] s;
      s = '0;
      for (int i = 0; i < KEY_BYTES && i < KEY_W / 8; i++) begin
         s = s + SUM_W'(key[8*i +: 8]);
      end
      return s;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/htp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module htp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ hw/rtl/htp_mod.sv @@
// Bit-serial restoring remainder unit: byte sum modulo active table size.
// Depends on htp_pkg.
`default_nettype none
module htp_mod
   import htp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output htp_mod_rsp_type       result
);

   typedef enum logic {
      MOD_IDLE,
      MOD_RUN
   } mod_state_type;

   mod_state_type     state_ff, state_in;
   logic [SUM_W-1:0]  dvd_ff, dvd_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;

   always_comb begin
      state_in = state_ff;
      dvd_in   = dvd_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, dvd_ff[SUM_W-1]};
      case (state_ff)
         MOD_IDLE: begin
            if (start) begin
               dvd_in   = dividend;
               div_in   = divisor;
               rem_in   = '0;
               step_in  = '0;
               state_in = MOD_RUN;
            end
         end
         MOD_RUN: begin
            dvd_in = {dvd_ff[SUM_W-2:0], 1'b0};
            if (trial >= {1'b0, div_ff}) begin
               rem_in = CNT_W'(trial - {1'b0, div_ff});
            end else begin
               rem_in = CNT_W'(trial);
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               done_in  = 1'b1;
               state_in = MOD_IDLE;
            end
         end
         default: begin
            state_in = MOD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MOD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      dvd_ff  <= dvd_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign result.done = done_ff;
   assign result.rem  = IDX_W'(rem_ff);

endmodule
`default_nettype wire

@@ hw/rtl/hash_table_triangular_probe_unit.sv @@
// Flow: capture the request, bit-serial modulo over the SUM_W (11) bits of the byte sum, hand over the
// remainder, then per probe a valid-bit check, plus a slot RAM read and key compare for a lookup of
// an occupied slot, then load the result; a held response stalls the unit in that last step.
// One transaction in flight: a new request is taken only when the unit is idle.
// Synchronous active-high reset clears all slot valid bits at once and sets table_size to 64.
// Slot keys and phones live in a 64-entry RAM and need no clearing.
// Depends on htp_pkg, htp_mod and htp_ram.
`default_nettype none
module hash_table_triangular_probe_unit
   import htp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [ENTRY_W-1:0]    req_tdata,   // key_name[63:0], phone_number[127:64]
   input  wire logic                  req_tuser,   // req_type[0]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [71:0]                rsp_tdata,   // phone_out[63:0], slot_index[69:64], zero
   output logic [STAT_W-1:0]          rsp_tuser,   // status[1:0]
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [PHONE_W-1:0]  phone_ff, phone_in;
   logic                lookup_ff, lookup_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [STAT_W-1:0]   res_status_ff, res_status_in;
   logic [PHONE_W-1:0]  res_phone_ff, res_phone_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [SIZE_W-1:0]   table_size_ff, table_size_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [PHONE_W-1:0]  rsp_phone_ff, rsp_phone_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;

   logic                mod_start;
   htp_mod_rsp_type     mod_rsp;
   logic                ram_we;
   logic                ram_re;
   logic [ENTRY_W-1:0]  ram_rd_data;
   logic [KEY_W-1:0]    req_key;
   logic [CNT_W-1:0]    active_n;
   logic [CNT_W-1:0]    count_nxt;
   logic [CNT_W:0]      wrap_sum;
   logic [IDX_W-1:0]    idx_nxt;
   logic                csr_wr;

   assign req_key = req_tdata[KEY_W-1:0] & key_mask();

   always_comb begin
      if (table_size_ff == '0) begin
         active_n = CNT_W'(1);
      end else if (32'(table_size_ff) > CAPACITY) begin
         active_n = CNT_W'(CAPACITY);
      end else begin
         active_n = CNT_W'(table_size_ff);
      end
   end

   assign count_nxt = count_ff + 1'b1;
   assign wrap_sum  = (CNT_W+1)'(idx_ff) + (CNT_W+1)'(count_nxt);
   assign idx_nxt   = (wrap_sum >= (CNT_W+1)'(n_ff)) ? IDX_W'(wrap_sum - (CNT_W+1)'(n_ff))
                                                      : IDX_W'(wrap_sum);

   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;

   htp_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (byte_sum(req_key)),
      .divisor  (active_n),
      .result   (mod_rsp)
   );

   htp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data ({phone_ff, key_ff}),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      phone_in      = phone_ff;
      lookup_in     = lookup_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_phone_in  = res_phone_ff;
      res_slot_in   = res_slot_ff;
      valid_in      = valid_ff;
      table_size_in = table_size_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_phone_in  = rsp_phone_ff;
      rsp_slot_in   = rsp_slot_ff;
      mod_start     = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      req_tready    = 1'b0;

      if (csr_wr && csr_paddr[2] == CSR_SEL_TABLE_SIZE) begin
         table_size_in = csr_pwdata[SIZE_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               key_in        = req_key;
               phone_in      = req_tdata[ENTRY_W-1:KEY_W];
               lookup_in     = req_tuser;
               n_in          = active_n;
               count_in      = '0;
               res_status_in = (req_tuser == REQ_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
               res_phone_in  = '0;
               res_slot_in   = '0;
               mod_start     = 1'b1;
               state_in      = ST_HASH;
            end
         end
         ST_HASH: begin
            if (mod_rsp.done) begin
               idx_in   = mod_rsp.rem;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (!valid_ff[idx_ff]) begin
               if (lookup_ff == REQ_INSERT) begin
                  ram_we           = 1'b1;
                  valid_in[idx_ff] = 1'b1;
                  res_status_in    = ST_INSERTED;
                  res_slot_in      = SLOT_W'(idx_ff);
               end
               state_in = ST_FINISH;
            end else if (lookup_ff == REQ_LOOKUP) begin
               ram_re   = 1'b1;
               state_in = ST_CHECK;
            end else if (count_nxt == n_ff) begin
               state_in = ST_FINISH;
            end else begin
               count_in = count_nxt;
               idx_in   = idx_nxt;
            end
         end
         ST_CHECK: begin
            if (ram_rd_data[KEY_W-1:0] == key_ff) begin
               res_status_in = ST_FOUND;
               res_phone_in  = ram_rd_data[ENTRY_W-1:KEY_W];
               res_slot_in   = SLOT_W'(idx_ff);
               state_in      = ST_FINISH;
            end else if (count_nxt == n_ff) begin
               state_in = ST_FINISH;
            end else begin
               count_in = count_nxt;
               idx_in   = idx_nxt;
               state_in = ST_PROBE;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_phone_in  = res_phone_ff;
               rsp_slot_in   = res_slot_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         table_size_ff <= TABLE_SIZE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         table_size_ff <= table_size_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      key_ff        <= key_in;
      phone_ff      <= phone_in;
      lookup_ff     <= lookup_in;
      n_ff          <= n_in;
      idx_ff        <= idx_in;
      count_ff      <= count_in;
      res_status_ff <= res_status_in;
      res_phone_ff  <= res_phone_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_phone_ff  <= rsp_phone_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_slot_ff, rsp_phone_ff};
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_SEL_TABLE_SIZE) ? CSR_DATA_W'(table_size_ff) : '0;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE || state_ff == ST_CHECK) |-> (CNT_W'(idx_ff) < n_ff))
      else $error("probe slot beyond active table size");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE || state_ff == ST_CHECK) |-> (count_ff < n_ff))
      else $error("probe count beyond active table size");

   a_check_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> ($past(state_ff) == ST_PROBE && $past(lookup_ff) == REQ_LOOKUP))
      else $error("key compare without a preceding slot read");

   a_phone_only_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_FOUND) |-> (rsp_phone_ff == '0))
      else $error("phone returned on a result other than found");

   a_insert_marks_valid: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> valid_ff[$past(idx_ff)])
      else $error("slot written without setting its valid bit");

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for hash_table_triangular_probe_unit: a phone directory model predicts
// each response; tasks drive the request stream and the APB port, and a process drives rsp_tready.
// Depends on htp_pkg and the RTL of the unit.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import htp_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] TABLE_SIZE_ADDR = '0;
   localparam int ITEMS_PER_PHASE = 85;
   localparam int QUIET_FROM      = 1400;
   localparam int LONG_HOLD       = 400;
   localparam int HOLD_AFTER      = 150;
   localparam int DRAIN_CYCLES    = 160;

   typedef struct {
      logic [STAT_W-1:0]  status;
      logic [PHONE_W-1:0] phone;
      logic [SLOT_W-1:0]  slot;
   } probe_outcome_type;

   class phone_directory_model;
      bit                 slot_used [CAPACITY];
      logic [KEY_W-1:0]   slot_name [CAPACITY];
      logic [PHONE_W-1:0] slot_tel  [CAPACITY];
      logic [SIZE_W-1:0]  size_reg;
      probe_outcome_type  pending_outcomes[$];
      int unsigned        errors;

      function new();
         size_reg = TABLE_SIZE_RESET;
         errors   = 0;
         foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
         end
      endfunction

      function void set_table_size(input logic [SIZE_W-1:0] value);
         size_reg = value;
      endfunction

      function void apply_request(input logic kind, input logic [KEY_W-1:0] name,
                                  input logic [PHONE_W-1:0] tel);
         logic [KEY_W-1:0]  masked;
         probe_outcome_type res;
         int unsigned       span;
         int unsigned       idx;
         int unsigned       step;
         int unsigned       sum;
         masked = '0;
         for (int b = 0; b < KEY_BYTES && b < KEY_W / 8; b++) begin
            masked[8*b +: 8] = name[8*b +: 8];
         end
         span = (size_reg == 0) ? 1 : ((size_reg > CAPACITY) ? CAPACITY : size_reg);
         sum = 0;
         for (int b = 0; b < KEY_W / 8; b++) begin
            sum += masked[8*b +: 8];
         end
         idx  = sum % span;
         step = 0;
         res.status = (kind == REQ_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
         res.phone  = '0;
         res.slot   = '0;
         for (int n = 0; n < span; n++) begin
            if (kind == REQ_INSERT) begin
               if (!slot_used[idx]) begin
                  slot_used[idx] = 1'b1;
                  slot_name[idx] = masked;
                  slot_tel[idx]  = tel;
                  res.status     = ST_INSERTED;
                  res.slot       = SLOT_W'(idx);
                  break;
               end
            end else begin
               if (!slot_used[idx]) break;
               if (slot_name[idx] == masked) begin
                  res.status = ST_FOUND;
                  res.phone  = slot_tel[idx];
                  res.slot   = SLOT_W'(idx);
                  break;
               end
            end
            step++;
            idx = (idx + step) % span;
         end
         pending_outcomes.insert(pending_outcomes.size(), res);
      endfunction

      function void compare_outcome(input logic [STAT_W-1:0] status,
                                    input logic [PHONE_W-1:0] tel,
                                    input logic [SLOT_W-1:0] slot);
         probe_outcome_type exp_res;
         if (pending_outcomes.size() == 0) begin
            $error("response transaction with no request outstanding");
            errors++;
            return;
         end
         exp_res = pending_outcomes.pop_front();
         if (status !== exp_res.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp_res.status, status);
            errors++;
         end
         if (tel !== exp_res.phone) begin
            $error("phone_out mismatch: expected %h, actual %h", exp_res.phone, tel);
            errors++;
         end
         if (slot !== exp_res.slot) begin
            $error("slot_index mismatch: expected %0d, actual %0d", exp_res.slot, slot);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [ENTRY_W-1:0]    req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [71:0]           rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   phone_directory_model directory = new();
   logic [KEY_W-1:0]     known_names[$];
   int unsigned          items_sent  = 0;
   bit                   quiet_tail  = 1'b0;

   hash_table_triangular_probe_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [KEY_W-1:0] random_name();
      logic [KEY_W-1:0] name;
      int unsigned      len;
      int unsigned      pick;
      name = '0;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         len = $urandom_range(1, 8);
         for (int b = 0; b < len; b++) begin
            name[8*b +: 8] = 8'($urandom_range(8'h41, 8'h7A));
         end
      end else if (pick < 8) begin
         name = {$urandom, $urandom};
      end else begin
         name[7:0] = 8'($urandom_range(0, 255));
      end
      return name;
   endfunction

   task automatic send_request(input logic kind, input logic [KEY_W-1:0] name,
                               input logic [PHONE_W-1:0] tel);
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {tel, name};
      do @(posedge clock); while (!req_tready);
      directory.apply_request(kind, name, tel);
      if (kind == REQ_INSERT) known_names.insert(known_names.size(), name);
      items_sent++;
      quiet_tail = (items_sent >= QUIET_FROM);
   endtask

   task automatic write_table_size(input logic [SIZE_W-1:0] value);
      req_tvalid <= 1'b0;
      while (directory.pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TABLE_SIZE_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      directory.set_table_size(value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic random_request();
      logic             kind;
      logic [KEY_W-1:0] name;
      kind = ($urandom_range(0, 99) < 35) ? REQ_INSERT : REQ_LOOKUP;
      if (known_names.size() != 0 && $urandom_range(0, 9) < 6) begin
         name = known_names[$urandom_range(0, known_names.size() - 1)];
      end else begin
         name = random_name();
      end
      send_request(kind, name, {$urandom, $urandom});
   endtask

   initial begin
      int unsigned rsp_count;
      bit          held;
      rsp_count  = 0;
      held       = 1'b0;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else if (!held && rsp_count >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            directory.compare_outcome(rsp_tuser, rsp_tdata[63:0], rsp_tdata[69:64]);
            rsp_count++;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      logic [SIZE_W-1:0] phase_sizes[$];
      phase_sizes = '{7'd3, 7'd5, 7'd1, 7'd7, 7'd0, 7'd10, 7'd13, 7'd16, 7'd20, 7'd127,
                      7'd24, 7'd31, 7'd40, 7'd48, 7'd55, 7'd63, 7'd2, 7'd64};
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = REQ_INSERT;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_table_size(7'd4);
      send_request(REQ_LOOKUP, 64'h0, {$urandom, $urandom});
      send_request(REQ_INSERT, 64'h0, {64{1'b1}});
      send_request(REQ_INSERT, {64{1'b1}}, 64'h0);
      send_request(REQ_INSERT, 64'h41, 64'h3535_3531_3233_3439);
      send_request(REQ_INSERT, 64'h0, 64'h0123_4567_89AB_CDEF);
      send_request(REQ_INSERT, 64'h42, 64'h3838_3838);
      send_request(REQ_LOOKUP, 64'h0, {$urandom, $urandom});
      send_request(REQ_LOOKUP, {64{1'b1}}, {64{1'b1}});
      send_request(REQ_LOOKUP, 64'h41, 64'h0);
      send_request(REQ_LOOKUP, 64'h42, {$urandom, $urandom});

      write_table_size(7'd0);
      send_request(REQ_INSERT, 64'h5A, 64'h39);
      send_request(REQ_LOOKUP, 64'h0, 64'h0);
      send_request(REQ_LOOKUP, 64'h41, 64'h0);

      write_table_size(7'd127);
      send_request(REQ_LOOKUP, 64'h41, 64'h0);
      send_request(REQ_INSERT, 64'h3F, 64'hAAAA_5555_AAAA_5555);
      send_request(REQ_LOOKUP, 64'h3F, 64'h0);
      send_request(REQ_INSERT, {64{1'b1}}, 64'h5555_AAAA_5555_AAAA);
      send_request(REQ_LOOKUP, 64'h51, 64'h0);

      write_table_size(7'd2);
      send_request(REQ_LOOKUP, 64'h3F, 64'h0);
      send_request(REQ_LOOKUP, 64'h0, 64'h0);

      foreach (phase_sizes[p]) begin
         write_table_size(phase_sizes[p]);
         repeat (ITEMS_PER_PHASE) random_request();
      end
      req_tvalid <= 1'b0;

      while (directory.pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (directory.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
